### hw/rtl/tfde_pkg.sv
package tfde_pkg;

	localparam int unsigned KEY_LEN = 11;
	localparam int unsigned IDX_W = 4;
	localparam int unsigned PID_W = 31;
	localparam logic [PID_W-1:0] PID_MAX = 31'h7fff_ffff;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Newline, then "TracerPid:"; index 0 is the line break itself.
	localparam logic [7:0] KEY_TEXT [0:KEY_LEN-1] = '{
		8'h0a, 8'h54, 8'h72, 8'h61, 8'h63, 8'h65,
		8'h72, 8'h50, 8'h69, 8'h64, 8'h3a
	};

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_BLANK  = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		V_CLEAN     = 3'd0,
		V_TRACED    = 3'd1,
		V_ABSENT    = 3'd2,
		V_MALFORMED = 3'd3,
		V_RANGE     = 3'd4
	} verdict_t;

	typedef struct packed {
		phase_t           phase;
		logic [IDX_W-1:0] key_idx;
		logic [PID_W-1:0] acc;
	} scan_state_t;

	typedef struct packed {
		logic             hit;
		verdict_t         verdict;
		logic [PID_W-1:0] pid;
	} scan_result_t;

	localparam scan_state_t SCAN_START = '{
		phase:   PH_SEARCH,
		key_idx: IDX_W'(1),
		acc:     '0
	};

endpackage

### hw/rtl/tfde_in_if.sv
interface tfde_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_buffer;

	modport source(output valid, output text_byte, output end_of_buffer, input ready);
	modport sink(input valid, input text_byte, input end_of_buffer, output ready);
endinterface

### hw/rtl/tfde_out_if.sv
interface tfde_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [30:0] tracer_pid;

	modport source(output valid, output verdict, output tracer_pid, input ready);
	modport sink(input valid, input verdict, input tracer_pid, output ready);
endinterface

### hw/rtl/tfde_scan.sv
module tfde_scan (
	input  tfde_pkg::scan_state_t  state,
	input  logic [7:0]             text_byte,
	input  logic                   end_of_buffer,
	output tfde_pkg::scan_state_t  state_next,
	output tfde_pkg::scan_result_t result
);
	import tfde_pkg::*;

	typedef struct packed {
		scan_state_t  nxt;
		scan_result_t res;
	} feed_t;

	// One byte of the scan; a NUL byte closes the buffer.
	function automatic feed_t feed(scan_state_t s, logic [7:0] b);
		feed_t            f;
		logic             is_digit;
		logic [3:0]       digit;
		logic [PID_W+3:0] n;
		f.nxt = s;
		f.res = '{hit: 1'b0, verdict: V_CLEAN, pid: '0};
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		digit = b[3:0];
		n = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {{PID_W{1'b0}}, digit};
		unique case (s.phase)
			PH_SEARCH: begin
				if (b == CH_NUL) begin
					f.res.hit = 1'b1;
					f.res.verdict = V_ABSENT;
				end else if (s.key_idx != '0 && s.key_idx < IDX_W'(KEY_LEN)
						&& b == KEY_TEXT[s.key_idx]) begin
					f.nxt.key_idx = s.key_idx + IDX_W'(1);
					if (s.key_idx == IDX_W'(KEY_LEN - 1))
						f.nxt.phase = PH_BLANK;
				end else begin
					f.nxt.key_idx = (b == CH_LF) ? IDX_W'(1) : '0;
				end
			end
			PH_BLANK: begin
				if (b == CH_SPACE || b == CH_TAB) begin
					f.nxt.phase = PH_BLANK;
				end else if (is_digit) begin
					f.nxt.acc = {{(PID_W-4){1'b0}}, digit};
					f.nxt.phase = PH_DIGITS;
				end else begin
					f.res.hit = 1'b1;
					f.res.verdict = V_MALFORMED;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					if (n > {4'd0, PID_MAX}) begin
						f.res.hit = 1'b1;
						f.res.verdict = V_RANGE;
					end else begin
						f.nxt.acc = n[PID_W-1:0];
					end
				end else if (b == CH_LF || b == CH_NUL) begin
					f.res.hit = 1'b1;
					if (s.acc == '0) begin
						f.res.verdict = V_CLEAN;
					end else begin
						f.res.verdict = V_TRACED;
						f.res.pid = s.acc;
					end
				end else begin
					f.res.hit = 1'b1;
					f.res.verdict = V_MALFORMED;
				end
			end
			PH_DONE: begin
				f.nxt = s;
			end
			default: begin
				f.nxt = s;
			end
		endcase
		if (b == CH_NUL)
			f.nxt = SCAN_START;
		else if (f.res.hit)
			f.nxt.phase = PH_DONE;
		return f;
	endfunction

	feed_t first;
	feed_t closing;
	logic  close_after;

	always_comb begin
		first = feed(state, text_byte);
		closing = feed(first.nxt, CH_NUL);
		close_after = end_of_buffer && (text_byte != CH_NUL);
	end

	// Next state: a flagged last byte is followed by an implied NUL.
	always_comb begin
		state_next = close_after ? closing.nxt : first.nxt;
	end

	// Result: the byte's own verdict wins over the implied end.
	always_comb begin
		if (first.res.hit || !close_after)
			result = first.res;
		else
			result = closing.res;
	end

endmodule

### hw/rtl/text_field_decimal_extractor.sv
// Scans status text one byte per item for the first line starting with
// "TracerPid:", skips blanks and reads the decimal pid. One result item
// (verdict plus pid) comes out per buffer, at the byte that settles it;
// a NUL byte or a byte flagged end_of_buffer closes the buffer and returns
// the scanner to its start state. Input items are taken one per cycle while
// the result register is free or being read: an input register feeds the
// byte-step logic, which updates the scan state and loads the result
// register in the same cycle. Input ready follows output ready whenever
// both registers are occupied.
module text_field_decimal_extractor (
	input  logic              clk,
	input  logic              arst_n,
	tfde_in_if.sink           text,
	tfde_out_if.source        report
);
	import tfde_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;

	scan_state_t  state_q;
	scan_state_t  state_next;
	scan_result_t step_res;

	logic         out_valid_q;
	verdict_t     verdict_q;
	logic [PID_W-1:0] pid_q;

	logic         out_free;
	logic         advance;

	assign out_free = !out_valid_q || report.ready;
	assign advance = valid_s1 && out_free;
	assign text.ready = !valid_s1 || out_free;

	tfde_scan u_scan (
		.state         (state_q),
		.text_byte     (byte_s1),
		.end_of_buffer (last_s1),
		.state_next    (state_next),
		.result        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.text_byte;
			last_s1 <= text.end_of_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_START;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && step_res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.hit) begin
			verdict_q <= step_res.verdict;
			pid_q <= step_res.pid;
		end
	end

	assign report.valid = out_valid_q;
	assign report.verdict = verdict_q;
	assign report.tracer_pid = pid_q;

	a_pid_only_traced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (verdict_q == V_TRACED) || (pid_q == '0))
		else $error("pid reported with a verdict other than traced");

	a_traced_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q == V_TRACED) |-> (pid_q != '0))
		else $error("traced verdict carries a zero pid");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(last_s1)))
		else $error("stalled input stage lost its item");

	a_key_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.key_idx <= IDX_W'(KEY_LEN))
		else $error("key match index past key length");

	a_result_only_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("result appeared without an item stepped");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import tfde_pkg::*;

	typedef enum int {
		CLOSE_NUL,
		CLOSE_LAST,
		CLOSE_NUL_LAST
	} close_kind_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_item_t;

	typedef struct packed {
		verdict_t         verdict;
		logic [PID_W-1:0] pid;
	} pid_report_t;

	logic clk = 1'b0;
	logic arst_n;

	tfde_in_if  text_if ();
	tfde_out_if report_if ();

	text_field_decimal_extractor i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.report (report_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scanner state as the block should hold it
	phase_t           scan_phase;
	logic [IDX_W-1:0] key_pos;
	logic [PID_W-1:0] pid_acc;

	text_item_t  pending_bytes [$];
	logic [7:0]  text_q [$];
	pid_report_t expected_reports [$];

	int mismatches = 0;
	int bytes_taken = 0;
	int live_items = 0;
	int buffers_closed = 0;
	int reports_checked = 0;
	int verdict_count [5] = '{default: 0};

	int in_idle, in_run, out_idle, out_run;
	text_item_t nxt;
	pid_report_t want;

	function automatic void restart_scan();
		scan_phase = PH_SEARCH;
		key_pos = IDX_W'(1);
		pid_acc = '0;
	endfunction

	// One byte through the scanner; returns 1 when it settles the verdict.
	function automatic bit scan_byte(input logic [7:0] b, output verdict_t v,
			output logic [PID_W-1:0] pid);
		logic [63:0] n;
		bit hit;
		hit = 1'b0;
		v = V_CLEAN;
		pid = '0;
		case (scan_phase)
			PH_SEARCH: begin
				if (b == CH_NUL) begin
					hit = 1'b1;
					v = V_ABSENT;
				end else if (key_pos >= 1 && key_pos < KEY_LEN && b == KEY_TEXT[key_pos]) begin
					key_pos = key_pos + 1'b1;
					if (key_pos >= KEY_LEN)
						scan_phase = PH_BLANK;
				end else begin
					key_pos = (b == CH_LF) ? IDX_W'(1) : IDX_W'(0);
				end
			end
			PH_BLANK: begin
				if (b == CH_SPACE || b == CH_TAB) begin
				end else if (b >= CH_ZERO && b <= CH_NINE) begin
					pid_acc = PID_W'(b - CH_ZERO);
					scan_phase = PH_DIGITS;
				end else begin
					hit = 1'b1;
					v = V_MALFORMED;
				end
			end
			PH_DIGITS: begin
				if (b >= CH_ZERO && b <= CH_NINE) begin
					n = 64'(pid_acc) * 64'd10 + 64'(b - CH_ZERO);
					if (n > 64'(PID_MAX)) begin
						hit = 1'b1;
						v = V_RANGE;
					end else begin
						pid_acc = PID_W'(n);
					end
				end else if (b == CH_LF || b == CH_NUL) begin
					hit = 1'b1;
					if (pid_acc == '0) begin
						v = V_CLEAN;
					end else begin
						v = V_TRACED;
						pid = pid_acc;
					end
				end else begin
					hit = 1'b1;
					v = V_MALFORMED;
				end
			end
			default: begin
			end
		endcase
		if (b == CH_NUL)
			restart_scan();
		else if (hit)
			scan_phase = PH_DONE;
		return hit;
	endfunction

	// A flagged non-NUL byte is handled, then the buffer closes as on a NUL.
	function automatic void predict_report(input logic [7:0] b, input logic last);
		verdict_t v, v_end;
		logic [PID_W-1:0] p, p_end;
		bit hit, hit_end;
		pid_report_t r;
		hit = scan_byte(b, v, p);
		if (last && b != CH_NUL) begin
			hit_end = scan_byte(CH_NUL, v_end, p_end);
			if (!hit && hit_end) begin
				hit = 1'b1;
				v = v_end;
				p = p_end;
			end
		end
		if (hit) begin
			r.verdict = v;
			r.pid = p;
			expected_reports.push_back(r);
		end
	endfunction

	function automatic int idle_len(inout int run);
		int r;
		if (run > 0) begin
			run--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			run = $urandom_range(30, 120);
			return 0;
		end
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	task automatic add_digits(input int count);
		for (int i = 0; i < count; i++)
			text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic close_buffer(input close_kind_t how);
		text_item_t it;
		if (how == CLOSE_LAST && text_q.size() == 0)
			how = CLOSE_NUL;
		foreach (text_q[i]) begin
			it.ch = text_q[i];
			it.last = (how == CLOSE_LAST && i == text_q.size() - 1);
			pending_bytes.push_back(it);
		end
		if (how != CLOSE_LAST) begin
			it.ch = CH_NUL;
			it.last = (how == CLOSE_NUL_LAST);
			pending_bytes.push_back(it);
		end
		text_q.delete();
	endtask

	task automatic make_random_buffer();
		int lines, r, start, len;
		lines = $urandom_range(0, 3);
		for (int l = 0; l < lines; l++) begin
			r = $urandom_range(0, 9);
			if (r < 4) begin
				len = $urandom_range(0, 8);
				for (int i = 0; i < len; i++)
					text_q.push_back(8'($urandom_range(32, 126)));
			end else if (r < 6) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					text_q.push_back(8'($urandom_range(1, 255)));
			end else if (r == 6) begin
				// truncated key, never complete
				len = $urandom_range(1, 9);
				for (int i = 1; i <= len; i++)
					text_q.push_back(KEY_TEXT[i]);
				add_str(" 7");
			end else if (r == 7) begin
				add_str(" TracerPid: 3");
			end else if (r == 8) begin
				add_str("Tracer: 1");
			end
			text_q.push_back(CH_LF);
		end
		if ($urandom_range(0, 9) < 8) begin
			start = text_q.size();
			add_str("TracerPid:");
			if ($urandom_range(0, 9) == 0)
				text_q[start + $urandom_range(0, 9)] = 8'($urandom_range(1, 255));
			len = $urandom_range(0, 3);
			for (int i = 0; i < len; i++)
				text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			r = $urandom_range(0, 19);
			if (r == 0) begin
			end else if (r == 1) begin
				add_str("2147483647");
			end else if (r == 2) begin
				add_str("2147483648");
			end else if (r == 3) begin
				add_digits($urandom_range(11, 14));
			end else if (r == 4) begin
				add_str("000");
				add_digits($urandom_range(1, 9));
			end else if (r < 7) begin
				text_q.push_back(CH_ZERO);
			end else begin
				text_q.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
				add_digits($urandom_range(0, 9));
			end
			r = $urandom_range(0, 9);
			if (r < 6) begin
				text_q.push_back(CH_LF);
				if ($urandom_range(0, 2) == 0)
					add_str("TracerPid: 9\n");
			end else if (r >= 8) begin
				do
					r = $urandom_range(1, 255);
				while (r == CH_LF);
				text_q.push_back(8'(r));
			end
		end
		close_buffer(close_kind_t'($urandom_range(0, 2)));
	endtask

	// Driver: feeds pending bytes, with random gaps between items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_if.valid <= 1'b0;
			text_if.text_byte <= '0;
			text_if.end_of_buffer <= 1'b0;
			in_idle = 0;
			in_run = 0;
		end else begin
			if (text_if.valid && text_if.ready) begin
				bytes_taken++;
				if (scan_phase != PH_DONE)
					live_items++;
				if (text_if.text_byte == CH_NUL || text_if.end_of_buffer)
					buffers_closed++;
				predict_report(text_if.text_byte, text_if.end_of_buffer);
			end
			if (!text_if.valid || text_if.ready) begin
				if (in_idle > 0) begin
					in_idle--;
					text_if.valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					nxt = pending_bytes.pop_front();
					text_if.valid <= 1'b1;
					text_if.text_byte <= nxt.ch;
					text_if.end_of_buffer <= nxt.last;
					in_idle = idle_len(in_run);
				end else begin
					text_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure, check each report against the oldest one due.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_if.ready <= 1'b0;
			out_idle = 0;
			out_run = 0;
		end else begin
			if (report_if.valid && report_if.ready) begin
				if (expected_reports.size() == 0) begin
					$error("unexpected report: verdict %0d tracer_pid %0d",
						report_if.verdict, report_if.tracer_pid);
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					reports_checked++;
					verdict_count[want.verdict]++;
					if (report_if.verdict !== want.verdict) begin
						$error("verdict: expected %0d, got %0d", want.verdict,
							report_if.verdict);
						mismatches++;
					end
					if (report_if.tracer_pid !== want.pid) begin
						$error("tracer_pid: expected %0d, got %0d", want.pid,
							report_if.tracer_pid);
						mismatches++;
					end
				end
			end
			if (out_idle > 0) begin
				out_idle--;
				report_if.ready <= 1'b0;
			end else begin
				report_if.ready <= 1'b1;
				out_idle = idle_len(out_run);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		text_if.valid = 1'b0;
		text_if.text_byte = '0;
		text_if.end_of_buffer = 1'b0;
		report_if.ready = 1'b0;
		restart_scan();

		add_str("TracerPid:\t0\n");
		close_buffer(CLOSE_NUL);
		add_str("x\nTracerPid: \t42\nA");
		close_buffer(CLOSE_NUL);
		add_str("State: R");
		close_buffer(CLOSE_LAST);
		close_buffer(CLOSE_NUL_LAST);
		add_str("TracerPid: -1");
		close_buffer(CLOSE_NUL);
		add_str("TracerPid:7a");
		close_buffer(CLOSE_NUL);
		add_str("TracerPid:");
		close_buffer(CLOSE_LAST);
		add_str("TracerPid:2147483647");
		close_buffer(CLOSE_LAST);
		add_str("TracerPid:2147483648\n");
		close_buffer(CLOSE_NUL_LAST);
		add_str(" TracerPid:5\n");
		text_q.push_back(8'hff);
		close_buffer(CLOSE_NUL);

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		while (live_items < 2000) begin
			if (pending_bytes.size() < 64)
				make_random_buffer();
			else
				@(negedge clk);
		end
		while (pending_bytes.size() > 0 || text_if.valid || expected_reports.size() > 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		$display("Scanned %0d bytes in %0d buffers, %0d reports checked.",
			bytes_taken, buffers_closed, reports_checked);
		$display("Verdicts: clean %0d, traced %0d, absent %0d, malformed %0d, range %0d.",
			verdict_count[V_CLEAN], verdict_count[V_TRACED], verdict_count[V_ABSENT],
			verdict_count[V_MALFORMED], verdict_count[V_RANGE]);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout: %0d reports still due", expected_reports.size());
		$display("tb_top failed");
		$finish;
	end

endmodule
